/* src/ubo_pkg.sv */
package ubo_pkg;

  // Largest frame the position counters are sized for.
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // Register and counter widths.
  localparam int DIM_W   = 13;
  localparam int BORDER_W = 12;
  localparam int COLOR_W = 8;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int INDEX_W = 3;

  // Configuration register indexes.
  typedef enum logic [INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_BORDER_WIDTH = 3'd2,
    REG_COLOR_RED    = 3'd3,
    REG_COLOR_GREEN  = 3'd4,
    REG_COLOR_BLUE   = 3'd5
  } reg_index_t;

  // Border color in the luma/chroma domain.
  typedef struct packed {
    logic [COLOR_W-1:0] y;
    logic [COLOR_W-1:0] u;
    logic [COLOR_W-1:0] v;
  } ycc_t;

endpackage

/* src/uyvy_border_overlay_unit.sv */
// A macropixel accepted on the input is registered and presented on the output
// in the cycle after its transaction.
// Throughput: one macropixel per cycle while out_ready is high; the single
// output register is refilled in the same cycle that its transaction completes.
// Reset clears the position counters and the output valid flag and loads the
// registers with 1920 x 1080, border 4, color red.
module uyvy_border_overlay_unit import ubo_pkg::*; (
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_write,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]    cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [COLOR_W-1:0]  in_u,
  input  logic [COLOR_W-1:0]  in_y1,
  input  logic [COLOR_W-1:0]  in_v,
  input  logic [COLOR_W-1:0]  in_y2,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  out_u,
  output logic [COLOR_W-1:0]  out_y1,
  output logic [COLOR_W-1:0]  out_v,
  output logic [COLOR_W-1:0]  out_y2,
  output logic                in_border,
  output logic                frame_end
);

  localparam int COLS_W = COL_W + 1;
  localparam int ROWS_W = ROW_W + 1;

  logic [DIM_W-1:0]    frame_width;
  logic [DIM_W-1:0]    frame_height;
  logic [BORDER_W-1:0] border_width;
  logic [COLOR_W-1:0]  color_red;
  logic [COLOR_W-1:0]  color_green;
  logic [COLOR_W-1:0]  color_blue;

  logic [COL_W-1:0]    column_count;
  logic [ROW_W-1:0]    row_count;
  logic [COL_W-1:0]    column_count_next;
  logic [ROW_W-1:0]    row_count_next;

  logic [DIM_W-1:0]    width_lim;
  logic [COLS_W-1:0]   cols;
  logic [ROWS_W-1:0]   rows;
  logic [DIM_W-1:0]    border_rows;
  logic                paint;
  logic                last_col;
  logic                last_row;
  logic                in_fire;
  ycc_t                border_color;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(1920);
      frame_height <= DIM_W'(1080);
      border_width <= BORDER_W'(4);
      color_red    <= COLOR_W'(255);
      color_green  <= '0;
      color_blue   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_BORDER_WIDTH: border_width <= cfg_data[BORDER_W-1:0];
        REG_COLOR_RED:    color_red    <= cfg_data[COLOR_W-1:0];
        REG_COLOR_GREEN:  color_green  <= cfg_data[COLOR_W-1:0];
        REG_COLOR_BLUE:   color_blue   <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  ubo_color_conv u_color_conv (
    .red   (color_red),
    .green (color_green),
    .blue  (color_blue),
    .color (border_color)
  );

  // Frame geometry, limited to the counter range and never empty.
  always_comb begin
    width_lim = (frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width;
    cols = COLS_W'(width_lim[DIM_W-1:1]);
    if (cols == '0) begin
      cols = COLS_W'(1);
    end
    rows = (frame_height > DIM_W'(MAX_HEIGHT)) ? ROWS_W'(MAX_HEIGHT)
                                               : ROWS_W'(frame_height);
    if (rows == '0) begin
      rows = ROWS_W'(1);
    end
    border_rows = {border_width, 1'b0};
  end

  // Border band test; the far-edge tests are written as sums to stay unsigned.
  assign paint = (DIM_W'(row_count) < border_rows)
              || ((DIM_W+1)'(row_count) + (DIM_W+1)'(border_rows) >= (DIM_W+1)'(rows))
              || (BORDER_W'(column_count) < border_width)
              || ((BORDER_W+1)'(column_count) + (BORDER_W+1)'(border_width)
                  >= (BORDER_W+1)'(cols));

  assign last_col = (COLS_W'(column_count) + COLS_W'(1)) >= cols;
  assign last_row = (ROWS_W'(row_count) + ROWS_W'(1)) >= rows;

  // Raster position update.
  always_comb begin
    column_count_next = column_count + COL_W'(1);
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + ROW_W'(1);
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // Output register: loads on every input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_u     <= paint ? border_color.u : in_u;
      out_y1    <= paint ? border_color.y : in_y1;
      out_v     <= paint ? border_color.v : in_v;
      out_y2    <= paint ? border_color.y : in_y2;
      in_border <= paint;
      frame_end <= last_col && last_row;
    end
  end

  // The frame's last macropixel returns the position to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_col && last_row |=> column_count == '0 && row_count == '0)
    else $error("position did not wrap after the last macropixel");

  // Position only moves on an input transaction.
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire && !$past(rst) |=> $stable(column_count) && $stable(row_count))
    else $error("position changed without an input transaction");

  // Every input transaction leaves a result waiting.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("input transaction produced no result");

  // A painted result has equal luma in both of its samples.
  a_paint_color: assert property (@(posedge clk) disable iff (rst)
    in_fire && paint |=> out_y1 == out_y2)
    else $error("painted macropixel has unequal luma");

endmodule

/* src/ubo_color_conv.sv */
module ubo_color_conv import ubo_pkg::*; (
  input  logic [COLOR_W-1:0] red,
  input  logic [COLOR_W-1:0] green,
  input  logic [COLOR_W-1:0] blue,
  output ycc_t               color
);

  localparam int SUM_W = 18;

  // Integer BT.601 coefficients.
  localparam logic signed [SUM_W-1:0] C_YR = 18'sd66;
  localparam logic signed [SUM_W-1:0] C_YG = 18'sd129;
  localparam logic signed [SUM_W-1:0] C_YB = 18'sd25;
  localparam logic signed [SUM_W-1:0] C_UR = -18'sd38;
  localparam logic signed [SUM_W-1:0] C_UG = -18'sd74;
  localparam logic signed [SUM_W-1:0] C_UB = 18'sd112;
  localparam logic signed [SUM_W-1:0] C_VR = 18'sd112;
  localparam logic signed [SUM_W-1:0] C_VG = -18'sd94;
  localparam logic signed [SUM_W-1:0] C_VB = -18'sd18;
  localparam logic signed [SUM_W-1:0] ROUND = 18'sd128;
  localparam logic signed [SUM_W-1:0] Y_OFFSET = 18'sd16;
  localparam logic signed [SUM_W-1:0] C_OFFSET = 18'sd128;

  logic signed [SUM_W-1:0] r_s, g_s, b_s;
  logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
  logic signed [SUM_W-1:0] y_full, u_full, v_full;

  // Saturate a signed value into one byte.
  function automatic logic [COLOR_W-1:0] clamp_byte(input logic signed [SUM_W-1:0] x);
    logic [COLOR_W-1:0] res;
    if (x < 0) begin
      res = '0;
    end else if (x > 18'sd255) begin
      res = '1;
    end else begin
      res = x[COLOR_W-1:0];
    end
    return res;
  endfunction

  assign r_s = signed'({{(SUM_W-COLOR_W){1'b0}}, red});
  assign g_s = signed'({{(SUM_W-COLOR_W){1'b0}}, green});
  assign b_s = signed'({{(SUM_W-COLOR_W){1'b0}}, blue});

  // Weighted sums with rounding bias; the shift floors toward minus infinity.
  assign y_sum = C_YR * r_s + C_YG * g_s + C_YB * b_s + ROUND;
  assign u_sum = C_UR * r_s + C_UG * g_s + C_UB * b_s + ROUND;
  assign v_sum = C_VR * r_s + C_VG * g_s + C_VB * b_s + ROUND;

  assign y_full = (y_sum >>> 8) + Y_OFFSET;
  assign u_full = (u_sum >>> 8) + C_OFFSET;
  assign v_full = (v_sum >>> 8) + C_OFFSET;

  assign color.y = clamp_byte(y_full);
  assign color.u = clamp_byte(u_full);
  assign color.v = clamp_byte(v_full);

endmodule

/* verif/uyvy_border_checker.sv */
`timescale 1ns / 1ps

// Watches the configuration port and both streams of the border overlay unit,
// keeps its own copy of the registers and position counters, and compares
// every output transaction with the predicted macropixel.
module uyvy_border_checker import ubo_pkg::*; (
  input  logic                clk,
  input  logic                rst,

  input  logic                cfg_write,
  input  logic [INDEX_W-1:0]  cfg_index,
  input  logic [DIM_W-1:0]    cfg_data,

  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [COLOR_W-1:0]  in_u,
  input  logic [COLOR_W-1:0]  in_y1,
  input  logic [COLOR_W-1:0]  in_v,
  input  logic [COLOR_W-1:0]  in_y2,

  input  logic                out_valid,
  input  logic                out_ready,
  input  logic [COLOR_W-1:0]  out_u,
  input  logic [COLOR_W-1:0]  out_y1,
  input  logic [COLOR_W-1:0]  out_v,
  input  logic [COLOR_W-1:0]  out_y2,
  input  logic                in_border,
  input  logic                frame_end,

  output int                  fail_count,
  output int                  pending,
  output int                  painted_count,
  output int                  frame_count
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [COLOR_W-1:0] u;
    logic [COLOR_W-1:0] y1;
    logic [COLOR_W-1:0] v;
    logic [COLOR_W-1:0] y2;
    logic               painted;
    logic               frame_last;
  } macropixel_t;

  // Shadow copies of the configuration registers.
  logic [DIM_W-1:0]    width_reg;
  logic [DIM_W-1:0]    height_reg;
  logic [BORDER_W-1:0] border_reg;
  logic [COLOR_W-1:0]  red_reg;
  logic [COLOR_W-1:0]  green_reg;
  logic [COLOR_W-1:0]  blue_reg;

  // Raster position of the next macropixel.
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;

  macropixel_t expected_pixels[$];
  int          mismatches;
  int          painted_seen;
  int          frames_seen;

  function automatic logic [COLOR_W-1:0] clamp_byte(int value);
    if (value < 0) return '0;
    if (value > 255) return 8'd255;
    return value[COLOR_W-1:0];
  endfunction

  // Integer BT.601 conversion; >>> on a signed int floors toward minus infinity.
  function automatic ycc_t border_color(int r, int g, int b);
    ycc_t c;
    c.y = clamp_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
    c.u = clamp_byte(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
    c.v = clamp_byte(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
    return c;
  endfunction

  // Predicts one output macropixel and advances the raster position.
  function automatic macropixel_t overlay_step(logic [COLOR_W-1:0] u, logic [COLOR_W-1:0] y1,
                                               logic [COLOR_W-1:0] v, logic [COLOR_W-1:0] y2);
    int          cols;
    int          rows;
    int          bw;
    int          col;
    int          row;
    logic        last_col;
    logic        last_row;
    ycc_t        c;
    macropixel_t res;

    cols = int'(width_reg);
    if (cols > MAX_WIDTH) cols = MAX_WIDTH;
    cols = cols / 2;
    if (cols < 1) cols = 1;
    rows = int'(height_reg);
    if (rows > MAX_HEIGHT) rows = MAX_HEIGHT;
    if (rows < 1) rows = 1;
    bw  = int'(border_reg);
    col = int'(col_pos);
    row = int'(row_pos);

    res.painted = (row < 2 * bw) || (row >= rows - 2 * bw) || (col < bw) || (col >= cols - bw);
    if (res.painted) begin
      c      = border_color(int'(red_reg), int'(green_reg), int'(blue_reg));
      res.u  = c.u;
      res.y1 = c.y;
      res.v  = c.v;
      res.y2 = c.y;
    end else begin
      res.u  = u;
      res.y1 = y1;
      res.v  = v;
      res.y2 = y2;
    end

    // A position at or past the last column or row wraps, even after a
    // register change left it out of range.
    last_col       = col >= cols - 1;
    last_row       = row >= rows - 1;
    res.frame_last = last_col && last_row;
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : ROW_W'(row + 1);
    end else begin
      col_pos = COL_W'(col + 1);
    end
    return res;
  endfunction

  // Track registers, predict on each input transaction, check each output one.
  always @(posedge clk) begin
    macropixel_t seen;
    macropixel_t want;

    if (rst) begin
      width_reg  = 13'd1920;
      height_reg = 13'd1080;
      border_reg = 12'd4;
      red_reg    = 8'd255;
      green_reg  = 8'd0;
      blue_reg   = 8'd0;
      col_pos    = '0;
      row_pos    = '0;
      expected_pixels.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_pixels.push_back(overlay_step(in_u, in_y1, in_v, in_y2));
      end

      if (out_valid && out_ready) begin
        seen = '{u: out_u, y1: out_y1, v: out_v, y2: out_y2,
                 painted: in_border, frame_last: frame_end};
        if (seen.painted) painted_seen++;
        if (seen.frame_last) frames_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: output transaction with nothing expected: u=%02h y1=%02h v=%02h y2=%02h",
                     $realtime, seen.u, seen.y1, seen.v, seen.y2);
          end
        end else begin
          want = expected_pixels.pop_front();
          if (seen.u !== want.u || seen.y1 !== want.y1 || seen.v !== want.v ||
              seen.y2 !== want.y2 || seen.painted !== want.painted ||
              seen.frame_last !== want.frame_last) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("%0t: mismatch u %02h/%02h y1 %02h/%02h v %02h/%02h y2 %02h/%02h",
                       $realtime, want.u, seen.u, want.y1, seen.y1,
                       want.v, seen.v, want.y2, seen.y2);
              $display("    in_border %0b/%0b frame_end %0b/%0b (expected/actual)",
                       want.painted, seen.painted, want.frame_last, seen.frame_last);
            end
          end
        end
      end

      // A write to an unused index changes nothing.
      if (cfg_write) begin
        case (cfg_index)
          REG_FRAME_WIDTH:  width_reg  = cfg_data;
          REG_FRAME_HEIGHT: height_reg = cfg_data;
          REG_BORDER_WIDTH: border_reg = cfg_data[BORDER_W-1:0];
          REG_COLOR_RED:    red_reg    = cfg_data[COLOR_W-1:0];
          REG_COLOR_GREEN:  green_reg  = cfg_data[COLOR_W-1:0];
          REG_COLOR_BLUE:   blue_reg   = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
    end

    fail_count    <= mismatches;
    pending       <= expected_pixels.size();
    painted_count <= painted_seen;
    frame_count   <= frames_seen;
  end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ubo_pkg::*;

  localparam int RANDOM_ITEMS = 1550;
  localparam int IDLE_PERCENT = 12;
  localparam int STALL_CYCLES = 60;
  localparam int DRAIN_CYCLES = 2;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [INDEX_W-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [INDEX_W-1:0] SPARE_INDEX_HI = 3'd7;

  logic               clk;
  logic               rst       = 1'b1;
  logic               cfg_write = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  logic [COLOR_W-1:0] in_u      = '0;
  logic [COLOR_W-1:0] in_y1     = '0;
  logic [COLOR_W-1:0] in_v      = '0;
  logic [COLOR_W-1:0] in_y2     = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COLOR_W-1:0] out_u;
  logic [COLOR_W-1:0] out_y1;
  logic [COLOR_W-1:0] out_v;
  logic [COLOR_W-1:0] out_y2;
  logic               in_border;
  logic               frame_end;

  int fail_count;
  int pending;
  int painted_count;
  int frame_count;

  // Shared controls: no idling on either side, and a one-time output stall.
  logic steady     = 1'b0;
  logic hold_armed = 1'b0;

  int macropixels_sent = 0;
  int settings_applied = 0;

  uyvy_border_overlay_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_u      (in_u),
    .in_y1     (in_y1),
    .in_v      (in_v),
    .in_y2     (in_y2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_u     (out_u),
    .out_y1    (out_y1),
    .out_v     (out_v),
    .out_y2    (out_y2),
    .in_border (in_border),
    .frame_end (frame_end)
  );

  uyvy_border_checker overlay_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_u          (in_u),
    .in_y1         (in_y1),
    .in_v          (in_v),
    .in_y2         (in_y2),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_u         (out_u),
    .out_y1        (out_y1),
    .out_v         (out_v),
    .out_y2        (out_y2),
    .in_border     (in_border),
    .frame_end     (frame_end),
    .fail_count    (fail_count),
    .pending       (pending),
    .painted_count (painted_count),
    .frame_count   (frame_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Overall time limit for the run.
  initial begin
    #2ms;
    $display("Run timed out with %0d results outstanding.", pending);
    $display("[uyvy_border_overlay_unit] ERROR");
    $finish;
  end

  // Output side: random back-pressure, one long stall when armed.
  initial begin
    int   hold_left;
    logic hold_taken;

    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = STALL_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Offers one macropixel, with random idle cycles ahead of it, and returns
  // at the edge where the transaction completes.
  task automatic send_macropixel(input logic [COLOR_W-1:0] u, input logic [COLOR_W-1:0] y1,
                                 input logic [COLOR_W-1:0] v, input logic [COLOR_W-1:0] y2);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_u     <= u;
    in_y1    <= y1;
    in_v     <= v;
    in_y2    <= y2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    macropixels_sent++;
  endtask

  task automatic send_random_pixels(input int count);
    repeat (count) begin
      send_macropixel(COLOR_W'($urandom), COLOR_W'($urandom),
                      COLOR_W'($urandom), COLOR_W'($urandom));
    end
  endtask

  // Holds the write enable high; the caller lowers it after the last write.
  task automatic write_register(input logic [INDEX_W-1:0] index, input logic [DIM_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Stops offering input and waits until every expected result has come out.
  task automatic wait_until_idle();
    in_valid  <= 1'b0;
    cfg_write <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes a random subset of registers, mostly small frames with
  // occasional extremes and out-of-range data bits.
  task automatic apply_random_setting();
    logic [DIM_W-1:0] value;

    if ($urandom_range(3) != 0) begin
      case ($urandom_range(9))
        0:       value = '0;
        1:       value = 13'd1;
        2:       value = 13'd4096;
        3:       value = '1;
        4:       value = DIM_W'($urandom);
        default: value = DIM_W'($urandom_range(24, 2));
      endcase
      write_register(REG_FRAME_WIDTH, value);
    end
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(9))
        0:       value = '0;
        1:       value = 13'd4096;
        2:       value = '1;
        3:       value = DIM_W'($urandom);
        default: value = DIM_W'($urandom_range(12, 1));
      endcase
      write_register(REG_FRAME_HEIGHT, value);
    end
    if ($urandom_range(3) != 0) begin
      case ($urandom_range(9))
        0:       value = '0;
        1:       value = 13'd4095;
        2:       value = DIM_W'($urandom);
        default: value = DIM_W'($urandom_range(3));
      endcase
      write_register(REG_BORDER_WIDTH, value);
    end
    if ($urandom_range(1) != 0) write_register(REG_COLOR_RED, DIM_W'($urandom));
    if ($urandom_range(1) != 0) write_register(REG_COLOR_GREEN, DIM_W'($urandom));
    if ($urandom_range(1) != 0) write_register(REG_COLOR_BLUE, DIM_W'($urandom));
    if ($urandom_range(3) == 0) begin
      write_register($urandom_range(1) ? SPARE_INDEX_LO : SPARE_INDEX_HI, DIM_W'($urandom));
    end
    cfg_write <= 1'b0;
    settings_applied++;
  endtask

  // Main stimulus and verdict.
  initial begin
    int random_sent;
    int phase;
    int count;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: the top rows of a 1080p frame fall in the border.
    send_macropixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    wait_until_idle();

    // Small 6x5 frame, border one macropixel wide and two rows high, white; spare indexes must not
    // disturb anything. The frame is finished from its current position.
    write_register(REG_FRAME_WIDTH, 13'd6);
    write_register(REG_FRAME_HEIGHT, 13'd5);
    write_register(REG_BORDER_WIDTH, 13'd1);
    write_register(REG_COLOR_RED, 13'd255);
    write_register(REG_COLOR_GREEN, 13'd255);
    write_register(REG_COLOR_BLUE, 13'd255);
    write_register(SPARE_INDEX_LO, '1);
    write_register(SPARE_INDEX_HI, '0);
    cfg_write <= 1'b0;
    settings_applied++;
    for (int i = 0; i < 13; i++) begin
      send_macropixel(i[0] ? 8'hFF : 8'h00, 8'hA5, i[0] ? 8'h00 : 8'hFF, 8'h5A);
    end
    wait_until_idle();

    // Zero width and height: each macropixel is a whole frame; black, no border.
    write_register(REG_FRAME_WIDTH, '0);
    write_register(REG_FRAME_HEIGHT, '0);
    write_register(REG_BORDER_WIDTH, '0);
    write_register(REG_COLOR_RED, '0);
    write_register(REG_COLOR_GREEN, '0);
    write_register(REG_COLOR_BLUE, '0);
    cfg_write <= 1'b0;
    settings_applied++;
    send_macropixel(8'h12, 8'h34, 8'h56, 8'h78);
    send_macropixel(8'hED, 8'hCB, 8'hA9, 8'h87);
    wait_until_idle();

    // Oversized width and height are clamped to the largest frame.
    write_register(REG_FRAME_WIDTH, '1);
    write_register(REG_FRAME_HEIGHT, '1);
    cfg_write <= 1'b0;
    settings_applied++;
    send_macropixel(8'h80, 8'h7F, 8'h01, 8'hFE);
    send_macropixel(8'h7F, 8'h80, 8'hFE, 8'h01);
    wait_until_idle();

    // A border wider than the frame paints everything; odd width of one.
    write_register(REG_BORDER_WIDTH, 13'd4095);
    write_register(REG_FRAME_WIDTH, 13'd1);
    write_register(REG_COLOR_BLUE, 13'd255);
    cfg_write <= 1'b0;
    settings_applied++;
    send_random_pixels(2);
    wait_until_idle();

    // Random phases; registers change between them, often mid-frame.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      apply_random_setting();
      count = $urandom_range(150, 20);
      if (phase == 2) begin
        steady = 1'b1;
        count  = 300;
      end else if (phase == 4) begin
        hold_armed = 1'b1;
        count      = 150;
      end
      send_random_pixels(count);
      random_sent += count;
      wait_until_idle();
      steady = 1'b0;
      phase++;
    end

    $display("Sent %0d macropixels under %0d register settings, with one long output stall.",
             macropixels_sent, settings_applied);
    $display("Results: %0d painted with the border color, %0d frame ends.",
             painted_count, frame_count);
    if (fail_count == 0 && pending == 0) begin
      $display("[uyvy_border_overlay_unit] OK");
    end else begin
      $display("[uyvy_border_overlay_unit] ERROR");
    end
    $finish;
  end

endmodule
